>>> rtl/core/gdrc_pkg.sv
// Shared types, codes and default constants of the grid DDA ray caster.
package gdrc_pkg;

  localparam int MAP_WIDTH_DEF     = 64;
  localparam int MAP_HEIGHT_DEF    = 64;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 22;
  localparam int DIM_W      = 13;
  localparam int POS_W      = 22;
  localparam int VEC_W      = 19;
  localparam int COL_W      = 12;
  localparam int CELL_W     = 6;
  localparam int DIST_W     = 32;
  localparam int LH_W       = 16;
  localparam int ROW_W      = 12;
  localparam int FACE_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH   = 3'd0,
    REG_SCREEN_HEIGHT  = 3'd1,
    REG_POSITION_X     = 3'd2,
    REG_POSITION_Y     = 3'd3,
    REG_DIRECTION_X    = 3'd4,
    REG_DIRECTION_Y    = 3'd5,
    REG_CAMERA_PLANE_X = 3'd6,
    REG_CAMERA_PLANE_Y = 3'd7
  } cfg_reg_t;

  localparam logic OP_MAP_WRITE = 1'b0;
  localparam logic OP_CAST      = 1'b1;

  localparam logic [FACE_W-1:0] FACE_NORTH = 2'd0;
  localparam logic [FACE_W-1:0] FACE_SOUTH = 2'd1;
  localparam logic [FACE_W-1:0] FACE_EAST  = 2'd2;
  localparam logic [FACE_W-1:0] FACE_WEST  = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CAM,
    ST_MUL,
    ST_RAY,
    ST_DDX,
    ST_DDY,
    ST_SIDE,
    ST_STEP,
    ST_CHECK,
    ST_DGO,
    ST_DIST,
    ST_LH,
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/gdrc_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module gdrc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/gdrc_div.sv
// Iterative restoring unsigned divider, one quotient bit per cycle.
module gdrc_div #(
  parameter int NUM_W = 48,
  parameter int DEN_W = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [NUM_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [DEN_W-1:0] rem_next;

  always_comb begin
    trial    = {rem, acc[NUM_W-1]};
    ge       = trial >= {1'b0, den_q};
    diff     = trial - {1'b0, den_q};
    rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      acc <= {acc[NUM_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign quo = acc;

endmodule

>>> rtl/core/grid_dda_ray_caster_core.sv
// Top level of the grid DDA ray caster: wall map, cast sequencer and result register.
//
//   Channel   Signals                                        Transaction
//   input     in_valid/in_ready, opcode..column              map write or cast
//   output    out_valid/out_ready, column_echo..out_of_map   one result per cast
//   config    cfg_we, cfg_index, cfg_data                    one register write
//
// A cast takes five passes of the shared bit-serial divider, setup and handoff
// states, and for each cell walked a step and a check of the registered wall map read.
// After reset the wall map is cleared one cell per cycle, while no input
// transaction is accepted.
// A finished result waits in the output register; map writes are still accepted
// then, and a further cast holds its result until the register is free.
module grid_dda_ray_caster_core #(
  parameter int MAP_WIDTH     = gdrc_pkg::MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT    = gdrc_pkg::MAP_HEIGHT_DEF,
  parameter int FRACTION_BITS = gdrc_pkg::FRACTION_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               opcode,
  input  logic [gdrc_pkg::CELL_W-1:0]        cell_x,
  input  logic [gdrc_pkg::CELL_W-1:0]        cell_y,
  input  logic                               cell_is_wall,
  input  logic [gdrc_pkg::COL_W-1:0]         column,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [gdrc_pkg::COL_W-1:0]         column_echo,
  output logic [gdrc_pkg::DIST_W-1:0]        wall_distance,
  output logic [gdrc_pkg::FACE_W-1:0]        wall_face,
  output logic [gdrc_pkg::CELL_W-1:0]        hit_x,
  output logic [gdrc_pkg::CELL_W-1:0]        hit_y,
  output logic [gdrc_pkg::LH_W-1:0]          line_height,
  output logic [gdrc_pkg::ROW_W-1:0]         draw_start,
  output logic [gdrc_pkg::ROW_W-1:0]         draw_end,
  output logic                               out_of_map,
  input  logic                               cfg_we,
  input  logic [gdrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gdrc_pkg::CFG_DATA_W-1:0]    cfg_data
);

  import gdrc_pkg::*;

  localparam int F        = FRACTION_BITS;
  localparam int DEPTH    = MAP_WIDTH * MAP_HEIGHT;
  localparam int AW       = $clog2(DEPTH);
  localparam int MAP_MAX  = (MAP_WIDTH > MAP_HEIGHT) ? MAP_WIDTH : MAP_HEIGHT;
  localparam int MAP_BITS = $clog2(MAP_MAX + 1);
  localparam int POS_INT  = POS_W - F;
  localparam int MC_W     = ((POS_INT > MAP_BITS) ? POS_INT : MAP_BITS) + 2;
  localparam int NUM_W    = MC_W + F + 1;
  localparam int DIV_W    = NUM_W + F;
  localparam int CAM_W    = DIM_W + 1 + F;
  localparam int PROD_W   = VEC_W + CAM_W;
  localparam int RX_W     = PROD_W - F + 1;
  localparam int DEN_W    = RX_W;
  localparam int SD_W     = DIST_W + 12;
  localparam int FR_W     = F + 1;
  localparam int SDP_W    = FR_W + DIST_W;
  localparam int GUARD    = 2 * (MAP_WIDTH + MAP_HEIGHT) + 4;
  localparam int G_W      = $clog2(GUARD);

  localparam logic signed [CAM_W-1:0] ONE_CAM = CAM_W'(1) << F;
  localparam logic signed [NUM_W-1:0] ONE_NUM = NUM_W'(1) << F;
  localparam logic [FR_W-1:0]         ONE_FR  = FR_W'(1) << F;

  state_t state, state_next;

  logic [DIM_W-1:0]        scr_w, scr_h;
  logic [POS_W-1:0]        pos_x, pos_y;
  logic signed [VEC_W-1:0] dir_x, dir_y, pln_x, pln_y;

  logic [AW-1:0]            clr_cnt;
  logic [COL_W-1:0]         col_q;
  logic signed [CAM_W-1:0]  cam;
  logic signed [PROD_W-1:0] prod_x, prod_y;
  logic signed [RX_W-1:0]   rx, ry;
  logic [DIST_W-1:0]        ddx, ddy;
  logic [SD_W-1:0]          sdx, sdy;
  logic signed [MC_W-1:0]   mx, my;
  logic                     side;
  logic                     oom;
  logic [G_W-1:0]           guard;
  logic [DIST_W-1:0]        wall_dist;
  logic [LH_W-1:0]          lh;

  logic [DIM_W-1:0]         sw_eff, sh_eff;
  logic                     accept;
  logic                     map_in_range;
  logic signed [RX_W-1:0]   rx_next, ry_next;
  logic [DEN_W-1:0]         rx_mag, ry_mag, rx_next_mag;
  logic [FR_W-1:0]          frac_x, frac_y;
  logic [SDP_W-1:0]         sdp_x, sdp_y;
  logic                     x_move;
  logic signed [MC_W-1:0]   mx_n, my_n;
  logic                     oom_n;
  logic signed [MC_W-1:0]   dcell;
  logic [POS_W-1:0]         dpos;
  logic                     dneg;
  logic signed [NUM_W-1:0]  dnum;
  logic [NUM_W-1:0]         dnum_mag;
  logic [DIST_W-1:0]        div_sat32;
  logic                     out_free;
  logic [ROW_W-1:0]         half;
  logic [LH_W-2:0]          lh2;
  logic [LH_W-1:0]          ds_full, de_full;
  logic [FACE_W-1:0]        face;
  logic signed [MC_W-1:0]   hx_full, hy_full;

  logic                     div_start;
  logic [DIV_W-1:0]         div_num;
  logic [DEN_W-1:0]         div_den;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quo;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic                     ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic                     ram_rdata;

  gdrc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  gdrc_div #(
    .NUM_W (DIV_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    sw_eff       = (scr_w == '0) ? DIM_W'(1) : scr_w;
    sh_eff       = (scr_h == '0) ? DIM_W'(1) : scr_h;
    accept       = in_valid && in_ready;
    map_in_range = (int'(cell_x) < MAP_WIDTH) && (int'(cell_y) < MAP_HEIGHT);
    rx_next      = RX_W'(dir_x) + RX_W'(prod_x >>> F);
    ry_next      = RX_W'(dir_y) + RX_W'(prod_y >>> F);
    rx_next_mag  = rx_next[RX_W-1] ? DEN_W'(-rx_next) : DEN_W'(rx_next);
    rx_mag       = rx[RX_W-1] ? DEN_W'(-rx) : DEN_W'(rx);
    ry_mag       = ry[RX_W-1] ? DEN_W'(-ry) : DEN_W'(ry);
    frac_x       = rx[RX_W-1] ? {1'b0, pos_x[F-1:0]} : ONE_FR - {1'b0, pos_x[F-1:0]};
    frac_y       = ry[RX_W-1] ? {1'b0, pos_y[F-1:0]} : ONE_FR - {1'b0, pos_y[F-1:0]};
    sdp_x        = SDP_W'(frac_x) * SDP_W'(ddx);
    sdp_y        = SDP_W'(frac_y) * SDP_W'(ddy);
    x_move       = sdx < sdy;
    mx_n         = mx;
    my_n         = my;
    if (x_move) begin
      mx_n = rx[RX_W-1] ? mx - MC_W'(1) : mx + MC_W'(1);
    end else begin
      my_n = ry[RX_W-1] ? my - MC_W'(1) : my + MC_W'(1);
    end
    oom_n = mx_n[MC_W-1] || (mx_n >= $signed(MC_W'(MAP_WIDTH))) ||
            my_n[MC_W-1] || (my_n >= $signed(MC_W'(MAP_HEIGHT)));
    dcell    = side ? my : mx;
    dpos     = side ? pos_y : pos_x;
    dneg     = side ? ry[RX_W-1] : rx[RX_W-1];
    dnum     = (NUM_W'(dcell) <<< F) - $signed(NUM_W'(dpos)) +
               (dneg ? ONE_NUM : NUM_W'(0));
    dnum_mag  = dnum[NUM_W-1] ? NUM_W'(-dnum) : NUM_W'(dnum);
    div_sat32 = (|div_quo[DIV_W-1:DIST_W]) ? '1 : div_quo[DIST_W-1:0];
    out_free  = !out_valid || out_ready;
    half      = sh_eff[DIM_W-1:1];
    lh2       = lh[LH_W-1:1];
    ds_full   = (LH_W'(lh2) >= LH_W'(half)) ? '0 : LH_W'(half) - LH_W'(lh2);
    de_full   = LH_W'(lh2) + LH_W'(half);
    if (de_full >= LH_W'(sh_eff)) begin
      de_full = LH_W'(sh_eff) - LH_W'(1);
    end
    if (side) begin
      face = (!ry[RX_W-1] && (ry != '0)) ? FACE_SOUTH : FACE_NORTH;
    end else begin
      face = rx[RX_W-1] ? FACE_EAST : FACE_WEST;
    end
    hx_full = mx[MC_W-1] ? '0 :
              (mx >= $signed(MC_W'(MAP_WIDTH))) ? MC_W'(MAP_WIDTH - 1) : mx;
    hy_full = my[MC_W-1] ? '0 :
              (my >= $signed(MC_W'(MAP_HEIGHT))) ? MC_W'(MAP_HEIGHT - 1) : my;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && (opcode == OP_CAST)) begin
          state_next = ST_CAM;
        end
      end
      ST_CAM: begin
        if (div_done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL: state_next = ST_RAY;
      ST_RAY: state_next = ST_DDX;
      ST_DDX: begin
        if (div_done) begin
          state_next = ST_DDY;
        end
      end
      ST_DDY: begin
        if (div_done) begin
          state_next = ST_SIDE;
        end
      end
      ST_SIDE: state_next = ST_STEP;
      ST_STEP: state_next = oom_n ? ST_DGO : ST_CHECK;
      ST_CHECK: begin
        if (ram_rdata || (guard == G_W'(GUARD - 1))) begin
          state_next = ST_DGO;
        end else begin
          state_next = ST_STEP;
        end
      end
      ST_DGO: state_next = ST_DIST;
      ST_DIST: begin
        if (div_done) begin
          state_next = ST_LH;
        end
      end
      ST_LH: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = 1'b0;
    ram_raddr = AW'(AW'(my_n) * AW'(MAP_WIDTH) + AW'(mx_n));
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && (opcode == OP_MAP_WRITE) && map_in_range) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(AW'(cell_y) * AW'(MAP_WIDTH) + AW'(cell_x));
          ram_wdata = cell_is_wall;
        end
        if (in_valid && (opcode == OP_CAST)) begin
          div_start = 1'b1;
          div_num   = DIV_W'({column, 1'b0}) << F;
          div_den   = DEN_W'(sw_eff);
        end
      end
      ST_RAY: begin
        div_start = 1'b1;
        div_num   = DIV_W'(1) << (2 * F);
        div_den   = rx_next_mag;
      end
      ST_DDX: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = DIV_W'(1) << (2 * F);
          div_den   = ry_mag;
        end
      end
      ST_DGO: begin
        div_start = 1'b1;
        div_num   = DIV_W'(dnum_mag) << F;
        div_den   = side ? ry_mag : rx_mag;
      end
      ST_DIST: begin
        if (div_done) begin
          div_start = 1'b1;
          div_num   = DIV_W'(sh_eff) << F;
          div_den   = DEN_W'(div_sat32);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_cnt   <= '0;
      out_valid <= 1'b0;
      scr_w     <= DIM_W'(640);
      scr_h     <= DIM_W'(480);
      pos_x     <= POS_W'(2097152);
      pos_y     <= POS_W'(2097152);
      dir_x     <= -VEC_W'(65536);
      dir_y     <= '0;
      pln_x     <= '0;
      pln_y     <= VEC_W'(43254);
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if ((state == ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_SCREEN_WIDTH:   scr_w <= cfg_data[DIM_W-1:0];
          REG_SCREEN_HEIGHT:  scr_h <= cfg_data[DIM_W-1:0];
          REG_POSITION_X:     pos_x <= cfg_data[POS_W-1:0];
          REG_POSITION_Y:     pos_y <= cfg_data[POS_W-1:0];
          REG_DIRECTION_X:    dir_x <= $signed(cfg_data[VEC_W-1:0]);
          REG_DIRECTION_Y:    dir_y <= $signed(cfg_data[VEC_W-1:0]);
          REG_CAMERA_PLANE_X: pln_x <= $signed(cfg_data[VEC_W-1:0]);
          REG_CAMERA_PLANE_Y: pln_y <= $signed(cfg_data[VEC_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        col_q <= column;
      end
      ST_CAM: begin
        if (div_done) begin
          cam <= $signed(CAM_W'(div_quo[CAM_W-2:0])) - ONE_CAM;
        end
      end
      ST_MUL: begin
        prod_x <= PROD_W'(pln_x) * PROD_W'(cam);
        prod_y <= PROD_W'(pln_y) * PROD_W'(cam);
      end
      ST_RAY: begin
        rx <= rx_next;
        ry <= ry_next;
      end
      ST_DDX: begin
        if (div_done) begin
          ddx <= div_sat32;
        end
      end
      ST_DDY: begin
        if (div_done) begin
          ddy <= div_sat32;
        end
      end
      ST_SIDE: begin
        sdx   <= SD_W'(sdp_x[SDP_W-1:F]);
        sdy   <= SD_W'(sdp_y[SDP_W-1:F]);
        mx    <= $signed(MC_W'(pos_x[POS_W-1:F]));
        my    <= $signed(MC_W'(pos_y[POS_W-1:F]));
        side  <= 1'b1;
        oom   <= 1'b0;
        guard <= '0;
      end
      ST_STEP: begin
        mx   <= mx_n;
        my   <= my_n;
        side <= !x_move;
        oom  <= oom_n;
        if (x_move) begin
          sdx <= sdx + SD_W'(ddx);
        end else begin
          sdy <= sdy + SD_W'(ddy);
        end
      end
      ST_CHECK: begin
        guard <= guard + 1'b1;
      end
      ST_DIST: begin
        if (div_done) begin
          wall_dist <= div_sat32;
        end
      end
      ST_LH: begin
        if (div_done) begin
          lh <= (|div_quo[DIV_W-1:LH_W]) ? '1 : div_quo[LH_W-1:0];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          column_echo   <= col_q;
          wall_distance <= wall_dist;
          wall_face     <= face;
          hit_x         <= hx_full[CELL_W-1:0];
          hit_y         <= hy_full[CELL_W-1:0];
          line_height   <= lh;
          draw_start    <= (|ds_full[LH_W-1:ROW_W]) ? '1 : ds_full[ROW_W-1:0];
          draw_end      <= (|de_full[LH_W-1:ROW_W]) ? '1 : de_full[ROW_W-1:0];
          out_of_map    <= oom;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> tb/grid_dda_ray_caster_core_test.sv
// Testbench of the grid DDA ray caster core: random and directed map writes and casts.
`timescale 1ns / 100ps

module grid_dda_ray_caster_core_test;
  import gdrc_pkg::*;

  localparam longint ONE_Q = 64'd65536;
  localparam longint SAT32 = 64'hFFFF_FFFF;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic [DIST_W-1:0] wall_dist;
    logic [FACE_W-1:0] face;
    logic [CELL_W-1:0] hx;
    logic [CELL_W-1:0] hy;
    logic [LH_W-1:0]   lh;
    logic [ROW_W-1:0]  ds;
    logic [ROW_W-1:0]  de;
    logic              oom;
  } wall_slice_t;

  class RayScoreboard;
    bit wall[4096];
    longint sw, sh, px, py, dx, dy, plx, ply;
    wall_slice_t pending_slices[$];
    int mismatches;

    function new();
      sw = 640;
      sh = 480;
      px = 2097152;
      py = 2097152;
      dx = -65536;
      dy = 0;
      plx = 0;
      ply = 43254;
      mismatches = 0;
    endfunction

    function longint sext19(logic [CFG_DATA_W-1:0] v);
      longint r;
      r = $signed(v[VEC_W-1:0]);
      return r;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_SCREEN_WIDTH: sw = v[DIM_W-1:0];
        REG_SCREEN_HEIGHT: sh = v[DIM_W-1:0];
        REG_POSITION_X: px = v;
        REG_POSITION_Y: py = v;
        REG_DIRECTION_X: dx = sext19(v);
        REG_DIRECTION_Y: dy = sext19(v);
        REG_CAMERA_PLANE_X: plx = sext19(v);
        REG_CAMERA_PLANE_Y: ply = sext19(v);
        default: ;
      endcase
    endfunction

    function longint floor_q(longint v);
      return (v >= 0) ? (v >>> 16) : -((-v + ONE_Q - 1) >>> 16);
    endfunction

    function longint absl(longint v);
      return (v < 0) ? -v : v;
    endfunction

    function longint delta_of(longint r);
      longint d;
      if (r == 0) return SAT32;
      d = (64'd1 << 32) / absl(r);
      return (d > SAT32) ? SAT32 : d;
    endfunction

    function longint perp(longint cell_idx, longint pos, int stp, longint r);
      longint num, d;
      if (r == 0) return SAT32;
      num = cell_idx * ONE_Q - pos + ((stp < 0) ? ONE_Q : 0);
      d = (absl(num) << 16) / absl(r);
      return (d > SAT32) ? SAT32 : d;
    endfunction

    function longint clamp_cell(longint c);
      return (c < 0) ? 0 : ((c > 63) ? 63 : c);
    endfunction

    function wall_slice_t cast_ray(logic [COL_W-1:0] col);
      wall_slice_t s;
      longint swv, shv, cam, rx, ry, mx, my, ddx, ddy, sdx, sdy, wall_dist, lh, ds, de, half;
      longint hxv, hyv;
      int stx, sty, side, oom;
      swv = (sw != 0) ? sw : 1;
      shv = (sh != 0) ? sh : 1;
      side = 1;
      oom = 0;
      cam = ((2 * longint'(col)) << 16) / swv - ONE_Q;
      rx = dx + floor_q(plx * cam);
      ry = dy + floor_q(ply * cam);
      mx = px >>> 16;
      my = py >>> 16;
      ddx = delta_of(rx);
      ddy = delta_of(ry);
      if (rx < 0) begin
        stx = -1;
        sdx = ((px - (mx << 16)) * ddx) >>> 16;
      end else begin
        stx = 1;
        sdx = (((mx << 16) + ONE_Q - px) * ddx) >>> 16;
      end
      if (ry < 0) begin
        sty = -1;
        sdy = ((py - (my << 16)) * ddy) >>> 16;
      end else begin
        sty = 1;
        sdy = (((my << 16) + ONE_Q - py) * ddy) >>> 16;
      end
      for (int g = 0; g < 260; g++) begin
        if (sdx < sdy) begin
          sdx += ddx;
          mx += stx;
          side = 0;
        end else begin
          sdy += ddy;
          my += sty;
          side = 1;
        end
        if (mx < 0 || mx > 63 || my < 0 || my > 63) begin
          oom = 1;
          break;
        end
        if (wall[my * 64 + mx]) break;
      end
      if (side == 1) s.face = (ry > 0) ? FACE_SOUTH : FACE_NORTH;
      else s.face = (rx < 0) ? FACE_EAST : FACE_WEST;
      wall_dist = (side == 0) ? perp(mx, px, stx, rx) : perp(my, py, sty, ry);
      if (wall_dist == 0) lh = 65535;
      else begin
        lh = (shv << 16) / wall_dist;
        if (lh > 65535) lh = 65535;
      end
      half = shv / 2;
      ds = (lh / 2 >= half) ? 0 : half - lh / 2;
      de = lh / 2 + half;
      if (de >= shv) de = shv - 1;
      if (ds > 4095) ds = 4095;
      if (de > 4095) de = 4095;
      hxv = clamp_cell(mx);
      hyv = clamp_cell(my);
      s.col = col;
      s.wall_dist = wall_dist[31:0];
      s.hx = hxv[CELL_W-1:0];
      s.hy = hyv[CELL_W-1:0];
      s.lh = lh[15:0];
      s.ds = ds[11:0];
      s.de = de[11:0];
      s.oom = oom[0];
      return s;
    endfunction

    function void note_input(logic op, logic [5:0] cx, logic [5:0] cy, logic w,
                             logic [COL_W-1:0] col);
      if (op == OP_MAP_WRITE) wall[cy * 64 + cx] = w;
      else pending_slices.push_back(cast_ray(col));
    endfunction

    function void check(wall_slice_t got);
      wall_slice_t want;
      if (pending_slices.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result for column %0d", got.col);
        return;
      end
      want = pending_slices.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Mismatch col %0d: exp dist=%h face=%0d hit=%0d,%0d lh=%0d ds=%0d de=%0d oom=%0d",
                   want.col, want.wall_dist, want.face, want.hx, want.hy, want.lh,
                   want.ds, want.de, want.oom);
          $display("  got col %0d dist=%h face=%0d hit=%0d,%0d lh=%0d ds=%0d de=%0d oom=%0d",
                   got.col, got.wall_dist, got.face, got.hx, got.hy, got.lh, got.ds,
                   got.de, got.oom);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  logic opcode = 0;
  logic [CELL_W-1:0] cell_x = 0;
  logic [CELL_W-1:0] cell_y = 0;
  logic cell_is_wall = 0;
  logic [COL_W-1:0] column = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [COL_W-1:0] column_echo;
  logic [DIST_W-1:0] wall_distance;
  logic [FACE_W-1:0] wall_face;
  logic [CELL_W-1:0] hit_x, hit_y;
  logic [LH_W-1:0] line_height;
  logic [ROW_W-1:0] draw_start, draw_end;
  logic out_of_map;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = 0;
  logic [CFG_DATA_W-1:0] cfg_data = 0;

  RayScoreboard slices = new();
  int idle_mode = 0;
  int quiet_cycles = 0;

  grid_dda_ray_caster_core u_top (.*);

  always #5 clk = ~clk;

  always @(negedge clk) begin
    case (idle_mode)
      2: out_ready = ($urandom_range(99) >= 84);
      3: out_ready = ($urandom_range(99) >= 27);
      default: out_ready = 1;
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      slices.check('{column_echo, wall_distance, wall_face, hit_x, hit_y, line_height,
                     draw_start, draw_end, out_of_map});
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function bit sender_idles();
    case (idle_mode)
      1: return $urandom_range(99) < 84;
      3: return $urandom_range(99) < 27;
      default: return 0;
    endcase
  endfunction

  task automatic send_item(logic op, logic [5:0] cx, logic [5:0] cy, logic w,
                           logic [COL_W-1:0] col);
    if (sender_idles()) begin
      in_valid = 0;
      do @(negedge clk); while (sender_idles());
    end
    in_valid = 1;
    opcode = op;
    cell_x = cx;
    cell_y = cy;
    cell_is_wall = w;
    column = col;
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    slices.note_input(op, cx, cy, w, col);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid = 0;
    while (slices.pending_slices.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = v;
    slices.write_reg(idx, v);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic write_all(logic [CFG_DATA_W-1:0] v[8]);
    for (int i = 0; i < 8; i++) write_reg(cfg_reg_t'(i), v[i]);
  endtask

  task automatic cast(logic [COL_W-1:0] col);
    send_item(OP_CAST, 6'd0, 6'd0, 1'b0, col);
  endtask

  task automatic put_cell(int x, int y, bit w);
    send_item(OP_MAP_WRITE, CELL_W'(x), CELL_W'(y), w, COL_W'($urandom));
  endtask

  task automatic random_items(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 50)
        send_item(OP_MAP_WRITE, CELL_W'($urandom), CELL_W'($urandom),
                  $urandom_range(99) < 35, COL_W'($urandom));
      else if ($urandom_range(99) < 75)
        cast(COL_W'($urandom_range(slices.sw)));
      else
        cast(COL_W'($urandom));
    end
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] v[8];
    repeat (10) @(negedge clk);
    rst = 0;

    cast(0);
    cast(4095);
    cast(320);
    put_cell(31, 32, 1);
    cast(320);
    put_cell(0, 0, 1);
    put_cell(63, 63, 1);
    put_cell(0, 63, 1);
    put_cell(63, 0, 1);
    put_cell(31, 32, 0);
    put_cell(10, 32, 1);
    put_cell(40, 20, 1);
    cast(0);
    cast(639);
    drain();

    v = '{0, 0, 22'h12345, 22'h2ABCD, 22'h10000, 22'h04000, 22'h00000, 22'h0A8F6};
    write_all(v);
    cast(0);
    cast(1);
    drain();
    v = '{2, 4096, 22'h200000, 22'h200000, 22'h7FFFF & -65536, 0, 0, 43254};
    write_all(v);
    cast(0);
    cast(1);
    cast(2);
    drain();

    for (int k = 0; k < 8; k++) begin
      case (k)
        0: v = '{8191, 8191, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFF, 22'h3FFFF, 22'h3FFFF,
                 22'h3FFFF};
        1: v = '{1, 1, 0, 0, 22'h40000, 22'h40000, 22'h40000, 22'h40000};
        default: begin
          v[0] = CFG_DATA_W'($urandom_range(1, 800));
          v[1] = CFG_DATA_W'($urandom_range(1, 1000));
          v[2] = CFG_DATA_W'($urandom);
          v[3] = CFG_DATA_W'($urandom);
          for (int j = 4; j < 8; j++)
            v[j] = CFG_DATA_W'(int'($urandom_range(0, 262143)) - 131072);
        end
      endcase
      if ($urandom_range(3) == 0) v[0] = CFG_DATA_W'($urandom);
      if ($urandom_range(3) == 0) v[1] = CFG_DATA_W'($urandom);
      write_all(v);
      idle_mode = k % 4;
      random_items(60);
      drain();
    end

    if (slices.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
